// File: rtl/core/png_unf_pkg.sv
// Shared types, constants and the Paeth predictor for the PNG scanline unfilter.
// Used by every module in rtl/core; depends on nothing else.
package png_unf_pkg;

  localparam int BYTE_W              = 8;
  localparam int CFG_W               = 4;
  localparam int MAX_LINE_BYTES_DEF  = 8192;
  localparam int MAX_PIXEL_BYTES_DEF = 8;

  typedef enum logic [1:0] {
    OP_SUB   = 2'd0,
    OP_UP    = 2'd1,
    OP_AVG   = 2'd2,
    OP_PAETH = 2'd3
  } op_t;

  typedef struct packed {
    logic [BYTE_W-1:0] left;
    logic [BYTE_W-1:0] upleft;
  } hist_tap_t;

  typedef struct packed {
    logic [BYTE_W-1:0] left;
    logic [BYTE_W-1:0] up;
    logic [BYTE_W-1:0] upleft;
  } nbr_t;

  function automatic logic [BYTE_W-1:0] paeth_pick(input logic [BYTE_W-1:0] a,
                                                   input logic [BYTE_W-1:0] b,
                                                   input logic [BYTE_W-1:0] c);
    logic signed [BYTE_W+1:0] sa;
    logic signed [BYTE_W+1:0] sb;
    logic signed [BYTE_W+1:0] sc;
    logic signed [BYTE_W+1:0] ta;
    logic signed [BYTE_W+1:0] tb;
    logic signed [BYTE_W+1:0] tc;
    logic [BYTE_W+1:0] da;
    logic [BYTE_W+1:0] db;
    logic [BYTE_W+1:0] dc;
    logic [BYTE_W-1:0] pick;
    sa = signed'({2'b00, a});
    sb = signed'({2'b00, b});
    sc = signed'({2'b00, c});
    ta = sb - sc;
    tb = sa - sc;
    tc = sa + sb - sc - sc;
    da = (ta < 0) ? unsigned'(-ta) : unsigned'(ta);
    db = (tb < 0) ? unsigned'(-tb) : unsigned'(tb);
    dc = (tc < 0) ? unsigned'(-tc) : unsigned'(tc);
    if (da <= db && da <= dc) begin
      pick = a;
    end else if (db <= dc) begin
      pick = b;
    end else begin
      pick = c;
    end
    return pick;
  endfunction

endpackage

// File: rtl/core/png_unf_line_store.sv
// Line store holding the previous reconstructed scanline, with registered read.
// A read that hits the address written in the same cycle returns the new byte.
// Depends on png_unf_pkg.
module png_unf_line_store #(
  parameter int DEPTH  = png_unf_pkg::MAX_LINE_BYTES_DEF,
  parameter int ADDR_W = $clog2(png_unf_pkg::MAX_LINE_BYTES_DEF)
) (
  input  logic                           clk,
  input  logic                           rd_en,
  input  logic [ADDR_W-1:0]              rd_addr,
  input  logic                           wr_en,
  input  logic [ADDR_W-1:0]              wr_addr,
  input  logic [png_unf_pkg::BYTE_W-1:0] wr_data,
  output logic [png_unf_pkg::BYTE_W-1:0] rd_data
);

  logic [png_unf_pkg::BYTE_W-1:0] mem [DEPTH];
  logic [png_unf_pkg::BYTE_W-1:0] rd_raw;
  logic [png_unf_pkg::BYTE_W-1:0] byp_data;
  logic                           byp_hit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_raw   <= mem[rd_addr];
      byp_hit  <= wr_en && (wr_addr == rd_addr);
      byp_data <= wr_data;
    end
  end

  assign rd_data = byp_hit ? byp_data : rd_raw;

endmodule

// File: rtl/core/png_unf_history.sv
// Shift lines of recent reconstructed bytes and of the above bytes used with them.
// The tap one pixel back is selected by the pixel size. Depends on png_unf_pkg.
module png_unf_history #(
  parameter int DEPTH = png_unf_pkg::MAX_PIXEL_BYTES_DEF,
  parameter int IDX_W = 3
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           shift_en,
  input  logic [png_unf_pkg::BYTE_W-1:0] left_in,
  input  logic [png_unf_pkg::BYTE_W-1:0] upleft_in,
  input  logic [IDX_W-1:0]               sel,
  output png_unf_pkg::hist_tap_t         tap
);

  logic [png_unf_pkg::BYTE_W-1:0] left_hist   [DEPTH];
  logic [png_unf_pkg::BYTE_W-1:0] upleft_hist [DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DEPTH; k++) begin
        left_hist[k]   <= '0;
        upleft_hist[k] <= '0;
      end
    end else if (shift_en) begin
      left_hist[0]   <= left_in;
      upleft_hist[0] <= upleft_in;
      for (int k = 1; k < DEPTH; k++) begin
        left_hist[k]   <= left_hist[k-1];
        upleft_hist[k] <= upleft_hist[k-1];
      end
    end
  end

  assign tap.left   = left_hist[sel];
  assign tap.upleft = upleft_hist[sel];

endmodule

// File: rtl/core/png_unf_predict.sv
// Predictor selection and modulo-256 reconstruction for one byte.
// Depends on png_unf_pkg.
module png_unf_predict (
  input  png_unf_pkg::op_t               op,
  input  logic [png_unf_pkg::BYTE_W-1:0] filtered_byte,
  input  png_unf_pkg::nbr_t              nbr,
  output logic [png_unf_pkg::BYTE_W-1:0] recon
);

  logic [png_unf_pkg::BYTE_W:0]   avg_sum;
  logic [png_unf_pkg::BYTE_W-1:0] pred;

  assign avg_sum = {1'b0, nbr.left} + {1'b0, nbr.up};

  always_comb begin
    unique case (op)
      png_unf_pkg::OP_SUB:   pred = nbr.left;
      png_unf_pkg::OP_UP:    pred = nbr.up;
      png_unf_pkg::OP_AVG:   pred = avg_sum[png_unf_pkg::BYTE_W:1];
      png_unf_pkg::OP_PAETH: pred = png_unf_pkg::paeth_pick(nbr.left, nbr.up, nbr.upleft);
      default:               pred = nbr.left;
    endcase
  end

  assign recon = filtered_byte + pred;

endmodule

// File: rtl/core/png_scanline_unfilter.sv
// Top level of the PNG scanline unfilter: column counter, stage and result registers.
// Instantiates png_unf_line_store, png_unf_history and png_unf_predict; uses png_unf_pkg.
//
//   channel  direction  handshake             payload
//   cfg      in         cfg_valid/cfg_ready   bytes_per_pixel
//   in       in         in_valid/in_stall     op, filtered_byte, line_start, first_row
//   out      out        out_valid/out_stall   recon_byte
//
// One byte is taken per cycle while the output is not stalled; a result passes the stage and result registers.
// The rate is set by the left-byte feedback through the predictor into the history.
// The line store read is issued at the input transfer and registered with the item.
// Reset clears the column, the pixel size (to one) and the history; the store is not cleared.
// A stall on the output holds the stage, and the input stalls only when the stage cannot move.
module png_scanline_unfilter #(
  parameter int MAX_LINE_BYTES  = png_unf_pkg::MAX_LINE_BYTES_DEF,
  parameter int MAX_PIXEL_BYTES = png_unf_pkg::MAX_PIXEL_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [png_unf_pkg::CFG_W-1:0]  bytes_per_pixel,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     op,
  input  logic [png_unf_pkg::BYTE_W-1:0] filtered_byte,
  input  logic                           line_start,
  input  logic                           first_row,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [png_unf_pkg::BYTE_W-1:0] recon_byte
);

  localparam int COL_W = $clog2(MAX_LINE_BYTES);
  localparam int IDX_W = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
  localparam int CMP_W = (COL_W > png_unf_pkg::CFG_W) ? COL_W : png_unf_pkg::CFG_W;

  logic [png_unf_pkg::CFG_W-1:0]  cfg_bpp;
  logic [png_unf_pkg::CFG_W-1:0]  bpp_eff;
  logic [IDX_W-1:0]               bpp_idx;

  logic [COL_W-1:0]               col_pos;
  logic [COL_W-1:0]               col_cur;
  logic [COL_W-1:0]               col_pos_next;

  logic                           accept;
  logic                           stg_adv;
  logic                           stg_valid;
  logic [1:0]                     stg_op;
  logic [png_unf_pkg::BYTE_W-1:0] stg_fb;
  logic                           stg_first;
  logic                           stg_has_left;
  logic [COL_W-1:0]               stg_col;

  logic [png_unf_pkg::BYTE_W-1:0] mem_rd_data;
  png_unf_pkg::hist_tap_t         tap;
  png_unf_pkg::nbr_t              nbr;
  logic [png_unf_pkg::BYTE_W-1:0] recon;

  assign cfg_ready = 1'b1;

  always_comb begin
    priority if (cfg_bpp == '0) begin
      bpp_eff = png_unf_pkg::CFG_W'(1);
    end else if (cfg_bpp > png_unf_pkg::CFG_W'(MAX_PIXEL_BYTES)) begin
      bpp_eff = png_unf_pkg::CFG_W'(MAX_PIXEL_BYTES);
    end else begin
      bpp_eff = cfg_bpp;
    end
  end

  assign bpp_idx = IDX_W'(bpp_eff - png_unf_pkg::CFG_W'(1));

  assign stg_adv  = stg_valid && (!out_valid || !out_stall);
  assign in_stall = stg_valid && !stg_adv;
  assign accept   = in_valid && !in_stall;

  assign col_cur      = line_start ? '0 : col_pos;
  assign col_pos_next = (col_cur == COL_W'(MAX_LINE_BYTES - 1)) ? '0 : col_cur + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_bpp   <= png_unf_pkg::CFG_W'(1);
      col_pos   <= '0;
      stg_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cfg_bpp <= bytes_per_pixel;
      end
      if (accept) begin
        col_pos <= col_pos_next;
      end
      if (accept) begin
        stg_valid <= 1'b1;
      end else if (stg_adv) begin
        stg_valid <= 1'b0;
      end
      if (stg_adv) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stg_op       <= op;
      stg_fb       <= filtered_byte;
      stg_first    <= first_row;
      stg_col      <= col_cur;
      stg_has_left <= CMP_W'(col_cur) >= CMP_W'(bpp_eff);
    end
    if (stg_adv) begin
      recon_byte <= recon;
    end
  end

  png_unf_line_store #(
    .DEPTH  (MAX_LINE_BYTES),
    .ADDR_W (COL_W)
  ) u_line_store (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col_cur),
    .wr_en   (stg_adv),
    .wr_addr (stg_col),
    .wr_data (recon),
    .rd_data (mem_rd_data)
  );

  assign nbr.up     = stg_first ? '0 : mem_rd_data;
  assign nbr.left   = stg_has_left ? tap.left : '0;
  assign nbr.upleft = stg_has_left ? tap.upleft : '0;

  png_unf_history #(
    .DEPTH (MAX_PIXEL_BYTES),
    .IDX_W (IDX_W)
  ) u_history (
    .clk       (clk),
    .rst       (rst),
    .shift_en  (stg_adv),
    .left_in   (recon),
    .upleft_in (nbr.up),
    .sel       (bpp_idx),
    .tap       (tap)
  );

  png_unf_predict u_predict (
    .op            (png_unf_pkg::op_t'(stg_op)),
    .filtered_byte (stg_fb),
    .nbr           (nbr),
    .recon         (recon)
  );

  a_stall_only_when_full : assert property (@(posedge clk) disable iff (rst)
    in_stall |-> stg_valid && out_valid && out_stall)
    else $error("input stalled while the stage could move");

  a_advance_gives_result : assert property (@(posedge clk) disable iff (rst)
    stg_adv |=> out_valid)
    else $error("stage moved without producing a result");

  a_line_start_column : assert property (@(posedge clk) disable iff (rst)
    accept && line_start |=> stg_valid && stg_col == '0)
    else $error("first byte of a line did not take column zero");

  a_stage_holds : assert property (@(posedge clk) disable iff (rst)
    stg_valid && !stg_adv |=> stg_valid && $stable(stg_col) && $stable(stg_fb))
    else $error("held stage item changed");

endmodule

// File: dv/png_unf_recon_check.sv
`timescale 1ns / 1ps
// Checker for png_scanline_unfilter: watches the config, input and output channels,
// reconstructs each accepted byte on its own and compares the results in order.
// Depends on png_unf_pkg for the filter codes and sizes.
module png_unf_recon_check (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [png_unf_pkg::CFG_W-1:0]  bytes_per_pixel,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [1:0]                     op,
  input  logic [png_unf_pkg::BYTE_W-1:0] filtered_byte,
  input  logic                           line_start,
  input  logic                           first_row,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [png_unf_pkg::BYTE_W-1:0] recon_byte,
  output int unsigned                    mismatches,
  output int unsigned                    outstanding
);

  localparam int BYTE_W      = png_unf_pkg::BYTE_W;
  localparam int CFG_W       = png_unf_pkg::CFG_W;
  localparam int LINE_BYTES  = png_unf_pkg::MAX_LINE_BYTES_DEF;
  localparam int PIXEL_BYTES = png_unf_pkg::MAX_PIXEL_BYTES_DEF;
  localparam int COL_W       = $clog2(LINE_BYTES);
  localparam int IDX_W       = $clog2(PIXEL_BYTES);

  logic [BYTE_W-1:0] prev_line [LINE_BYTES];
  logic [BYTE_W-1:0] left_hist [PIXEL_BYTES];
  logic [BYTE_W-1:0] upleft_hist [PIXEL_BYTES];
  logic [CFG_W-1:0]  pixel_size;
  int unsigned       col;
  logic [BYTE_W-1:0] recon_due [$];

  function automatic int paeth_choice(input int a, input int b, input int c);
    int p;
    int pa;
    int pb;
    int pc;
    p  = a + b - c;
    pa = (p > a) ? p - a : a - p;
    pb = (p > b) ? p - b : b - p;
    pc = (p > c) ? p - c : c - p;
    if (pa <= pb && pa <= pc) begin
      return a;
    end else if (pb <= pc) begin
      return b;
    end
    return c;
  endfunction

  function automatic logic [BYTE_W-1:0] reconstruct(input png_unf_pkg::op_t f,
                                                    input logic [BYTE_W-1:0] fb,
                                                    input logic start, input logic first);
    int step;
    int left;
    int up;
    int upleft;
    int guess;
    logic [BYTE_W-1:0] raw;
    step = (pixel_size == '0) ? 1 :
           ((int'(pixel_size) > PIXEL_BYTES) ? PIXEL_BYTES : int'(pixel_size));
    left = 0;
    up = 0;
    upleft = 0;
    if (start) begin
      col = 0;
    end
    if (col >= LINE_BYTES) begin
      col = 0;
    end
    if (!first) begin
      up = int'(prev_line[COL_W'(col)]);
    end
    if (col >= step) begin
      left   = int'(left_hist[IDX_W'(step - 1)]);
      upleft = int'(upleft_hist[IDX_W'(step - 1)]);
    end
    case (f)
      png_unf_pkg::OP_SUB: begin
        guess = left;
      end
      png_unf_pkg::OP_UP: begin
        guess = up;
      end
      png_unf_pkg::OP_AVG: begin
        guess = (left + up) / 2;
      end
      default: begin
        guess = paeth_choice(left, up, upleft);
      end
    endcase
    raw = BYTE_W'(fb + guess);
    prev_line[COL_W'(col)] = raw;
    for (int k = PIXEL_BYTES - 1; k > 0; k--) begin
      left_hist[k]   = left_hist[k-1];
      upleft_hist[k] = upleft_hist[k-1];
    end
    left_hist[0]   = raw;
    upleft_hist[0] = BYTE_W'(up);
    col = (col + 1 >= LINE_BYTES) ? 0 : col + 1;
    return raw;
  endfunction

  always @(posedge clk) begin
    logic [BYTE_W-1:0] want;
    if (rst) begin
      pixel_size = CFG_W'(1);
      col = 0;
      for (int k = 0; k < PIXEL_BYTES; k++) begin
        left_hist[k]   = '0;
        upleft_hist[k] = '0;
      end
      recon_due.delete();
      mismatches  <= 0;
      outstanding <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        pixel_size = bytes_per_pixel;
      end
      if (in_valid && !in_stall) begin
        recon_due.push_back(reconstruct(png_unf_pkg::op_t'(op), filtered_byte, line_start,
                                        first_row));
      end
      if (out_valid && !out_stall) begin
        if (recon_due.size() == 0) begin
          $display("%0t: recon_byte expected none, actual %02h", $time, recon_byte);
          mismatches <= mismatches + 1;
        end else begin
          want = recon_due.pop_front();
          if (want !== recon_byte) begin
            $display("%0t: recon_byte expected %02h, actual %02h", $time, want, recon_byte);
            mismatches <= mismatches + 1;
          end
        end
      end
      outstanding <= $unsigned(recon_due.size());
    end
  end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// Top of the png_scanline_unfilter testbench: clock, reset, stimulus and verdict.
// Instantiates the block and png_unf_recon_check; uses png_unf_pkg.
module testbench;

  localparam int LINE_BYTES = png_unf_pkg::MAX_LINE_BYTES_DEF;
  localparam int BYTE_W     = png_unf_pkg::BYTE_W;
  localparam int CFG_W      = png_unf_pkg::CFG_W;

  logic              clk;
  logic              rst = 1'b1;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_W-1:0]  bytes_per_pixel = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        op = '0;
  logic [BYTE_W-1:0] filtered_byte = '0;
  logic              line_start = 1'b0;
  logic              first_row = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [BYTE_W-1:0] recon_byte;
  int unsigned       mismatches;
  int unsigned       outstanding;

  int unsigned burst_left = 0;
  int unsigned track_col = 0;
  int unsigned written_span = 0;
  int unsigned cycle_no = 0;
  int unsigned hold_left = 0;

  png_scanline_unfilter i_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .bytes_per_pixel(bytes_per_pixel),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .op             (op),
    .filtered_byte  (filtered_byte),
    .line_start     (line_start),
    .first_row      (first_row),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .recon_byte     (recon_byte)
  );

  png_unf_recon_check i_recon_check (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .bytes_per_pixel(bytes_per_pixel),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .op             (op),
    .filtered_byte  (filtered_byte),
    .line_start     (line_start),
    .first_row      (first_row),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .recon_byte     (recon_byte),
    .mismatches     (mismatches),
    .outstanding    (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("png_scanline_unfilter: mismatch");
    $finish;
  end

  // A long hold-off recurs so that the block fills up and stalls its input.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      cycle_no  <= 0;
      hold_left <= 0;
    end else begin
      cycle_no <= cycle_no + 1;
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (cycle_no % 900 == 450) begin
        out_stall <= 1'b1;
        hold_left <= 60;
      end else begin
        case ((cycle_no / 250) % 4)
          0: begin
            out_stall <= 1'b0;
          end
          1: begin
            out_stall <= ($urandom_range(0, 3) == 0);
          end
          2: begin
            out_stall <= ($urandom_range(0, 9) < 7);
          end
          default: begin
            out_stall <= cycle_no[0];
          end
        endcase
      end
    end
  end

  // A column that has not been written is always offered as a first-row byte, so its stored value is not used.
  task automatic offer_byte(input png_unf_pkg::op_t f, input logic [BYTE_W-1:0] fb,
                            input logic start, input logic first);
    int unsigned gap;
    int unsigned c;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 1) == 0) ? 0 :
            (($urandom_range(0, 9) == 0) ? $urandom_range(15, 30) : $urandom_range(1, 8));
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    c = start ? 0 : track_col;
    if (c >= LINE_BYTES) begin
      c = 0;
    end
    if (c >= written_span) begin
      first = 1'b1;
    end
    in_valid      <= 1'b1;
    op            <= f;
    filtered_byte <= fb;
    line_start    <= start;
    first_row     <= first;
    do @(posedge clk); while (in_stall);
    if (c + 1 > written_span) begin
      written_span = c + 1;
    end
    track_col = (c + 1 >= LINE_BYTES) ? 0 : c + 1;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic set_pixel_size(input logic [CFG_W-1:0] v);
    settle();
    cfg_valid       <= 1'b1;
    bytes_per_pixel <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_line(input int unsigned len, input png_unf_pkg::op_t f,
                           input logic first_line);
    png_unf_pkg::op_t  g;
    logic              fr;
    logic [BYTE_W-1:0] fb;
    for (int unsigned i = 0; i < len; i++) begin
      g  = ($urandom_range(0, 19) == 0) ? png_unf_pkg::op_t'($urandom_range(0, 3)) : f;
      fr = ($urandom_range(0, 14) == 0) ? ~first_line : first_line;
      case ($urandom_range(0, 15))
        0: begin
          fb = 8'h00;
        end
        1: begin
          fb = 8'hFF;
        end
        default: begin
          fb = BYTE_W'($urandom_range(0, 255));
        end
      endcase
      offer_byte(g, fb, (i == 0) || ($urandom_range(0, 49) == 0), fr);
    end
  endtask

  task automatic run_lines(input int unsigned items);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < items) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(65, 300) : $urandom_range(1, 48);
      send_line(len, png_unf_pkg::op_t'($urandom_range(0, 3)), $urandom_range(0, 6) == 0);
      sent += len;
    end
  endtask

  initial begin
    logic [CFG_W-1:0] sizes [9];
    sizes = '{4'd8, 4'd2, 4'd1, 4'd4, 4'd0, 4'd15, 4'd7, 4'd0, 4'd5};
    sizes[4] = CFG_W'($urandom_range(0, 15));
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // First row, then a second row that uses the stored line, at the reset pixel size.
    offer_byte(png_unf_pkg::OP_SUB, 8'h00, 1'b1, 1'b1);
    offer_byte(png_unf_pkg::OP_UP, 8'hFF, 1'b0, 1'b1);
    offer_byte(png_unf_pkg::OP_AVG, 8'h80, 1'b0, 1'b1);
    offer_byte(png_unf_pkg::OP_PAETH, 8'h7F, 1'b0, 1'b1);
    offer_byte(png_unf_pkg::OP_PAETH, 8'hFF, 1'b1, 1'b0);
    offer_byte(png_unf_pkg::OP_AVG, 8'h01, 1'b0, 1'b0);
    offer_byte(png_unf_pkg::OP_UP, 8'h55, 1'b0, 1'b0);
    offer_byte(png_unf_pkg::OP_SUB, 8'hAA, 1'b0, 1'b0);
    offer_byte(png_unf_pkg::OP_PAETH, 8'h00, 1'b1, 1'b0);
    offer_byte(png_unf_pkg::OP_PAETH, 8'h10, 1'b0, 1'b0);
    offer_byte(png_unf_pkg::OP_AVG, 8'hFF, 1'b0, 1'b0);
    offer_byte(png_unf_pkg::OP_UP, 8'h00, 1'b0, 1'b0);

    // A pixel size of zero acts as one, and sizes above eight act as eight.
    set_pixel_size(4'd0);
    for (int i = 0; i < 4; i++) begin
      offer_byte(png_unf_pkg::OP_SUB, BYTE_W'(8'hF0 + i), i == 0, 1'b0);
    end
    set_pixel_size(4'd15);
    for (int i = 0; i < 8; i++) begin
      offer_byte(png_unf_pkg::OP_PAETH, BYTE_W'(8'h11 * i), i == 0, 1'b0);
    end

    foreach (sizes[k]) begin
      set_pixel_size(sizes[k]);
      run_lines(140);
    end

    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("png_scanline_unfilter: match");
    end else begin
      $display("png_scanline_unfilter: mismatch");
    end
    $finish;
  end

endmodule
